>>> sv/wpm_pkg.sv
// Package for the wildcard pattern matcher: opcodes, pattern byte codes and defaults.
// Used by wpm_row_update and wildcard_pattern_matcher; no dependencies.
package wpm_pkg;

  // default pattern capacity in bytes
  localparam int PATTERN_MAX_DEF = 32;

  // pattern bytes with a wildcard meaning
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  // operation carried in tuser of the input stream
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_EMPTY  = 2'd3
  } opcode_t;

endpackage

>>> sv/wpm_row_update.sv
// Next match row for one text byte: per-position byte compare and a parallel prefix
// over star runs. Depends on wpm_pkg.
module wpm_row_update #(
  parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
  input  logic [PATTERN_MAX:0] row,
  input  logic [7:0]           store [PATTERN_MAX],
  input  logic [7:0]           sym,
  output logic [PATTERN_MAX:0] next_row
);
  import wpm_pkg::*;

  localparam int LV = $clog2(PATTERN_MAX + 1);

  // generate / propagate terms, one set per prefix level
  logic [PATTERN_MAX:0] g_lvl [LV + 1];
  logic [PATTERN_MAX:0] p_lvl [LV + 1];

  // position terms, then log-depth prefix: next[j] = g[j] | p[j] & next[j-1]
  always_comb begin
    // a star passes the bit to its left, others take the diagonal
    g_lvl[0][0] = 1'b0;
    p_lvl[0][0] = 1'b0;
    for (int j = 1; j <= PATTERN_MAX; j++) begin
      p_lvl[0][j] = (store[j-1] == STAR_BYTE);
      g_lvl[0][j] = (store[j-1] == STAR_BYTE) ? row[j] :
                    (row[j-1] & ((store[j-1] == sym) | (store[j-1] == ANY_BYTE)));
    end
    for (int lv = 0; lv < LV; lv++) begin
      for (int j = 0; j <= PATTERN_MAX; j++) begin
        if (j >= (1 << lv)) begin
          g_lvl[lv+1][j] = g_lvl[lv][j] | (p_lvl[lv][j] & g_lvl[lv][j - (1 << lv)]);
          p_lvl[lv+1][j] = p_lvl[lv][j] & p_lvl[lv][j - (1 << lv)];
        end else begin
          g_lvl[lv+1][j] = g_lvl[lv][j];
          p_lvl[lv+1][j] = p_lvl[lv][j];
        end
      end
    end
  end

  assign next_row = g_lvl[LV];

endmodule

>>> sv/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: input register, pattern store, row state
// and result register. Depends on wpm_pkg and wpm_row_update.
//
// Glob matcher over byte text: '*' matches any run, '?' any one byte. Load a pattern
// with a clear transfer and append transfers, then stream text bytes with tlast on the
// final byte; an empty-text transfer asks about the empty string. One transfer is
// taken every clock cycle unless the input stalls. Each text byte updates the whole
// match row at once through a byte compare per pattern position and a log-depth
// prefix over runs of stars, so there is no per-byte loop. A result (matched,
// overflow) passes from the input register to the output register; the input stalls
// only while a result-bearing transfer waits on a full output register.
module wildcard_pattern_matcher #(
  parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic [1:0] s_tuser,   // [1:0] opcode
  input  logic       s_tlast,   // last_of_text
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import wpm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [PATTERN_MAX:0] ROW_RESET = (PATTERN_MAX + 1)'(1);

  // input register
  logic        s1_valid;
  opcode_t     s1_op;
  logic [7:0]  s1_sym;
  logic        s1_last;

  // pattern and row state
  logic [7:0]           store [PATTERN_MAX];
  logic [LW-1:0]        pat_len;
  logic                 ovf;
  logic [PATTERN_MAX:0] init_row;
  logic [PATTERN_MAX:0] match_row;

  logic [PATTERN_MAX:0] text_row;
  logic [PATTERN_MAX:0] init_row_next;
  logic [LW-1:0]        len_inc;
  logic                 has_room;
  logic                 gives_result;
  logic                 s1_adv;
  logic                 hit;

  wpm_row_update #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_row (
    .row      (match_row),
    .store    (store),
    .sym      (s1_sym),
    .next_row (text_row)
  );

  // handshake: only a result-bearing item can stall behind the output register
  assign gives_result = (s1_op == OP_EMPTY) || ((s1_op == OP_TEXT) && s1_last);
  assign s1_adv       = s1_valid && (!gives_result || !m_tvalid || m_tready);
  assign s_tready     = !s1_valid || s1_adv;

  // initial row after an append
  assign has_room = (pat_len < LW'(PATTERN_MAX));
  assign len_inc  = pat_len + 1'b1;
  always_comb begin
    init_row_next = init_row;
    init_row_next[len_inc] = init_row[pat_len] && (s1_sym == STAR_BYTE);
  end

  // match bit for the result
  assign hit = (s1_op == OP_TEXT) ? text_row[pat_len] : init_row[pat_len];

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      s1_op   <= opcode_t'(s_tuser);
      s1_sym  <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  // pattern store write
  always_ff @(posedge clk) begin
    if (s1_adv && (s1_op == OP_APPEND) && has_room) begin
      store[pat_len[AW-1:0]] <= s1_sym;
    end
  end

  // pattern length, overflow flag and rows
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      ovf       <= 1'b0;
      init_row  <= ROW_RESET;
      match_row <= ROW_RESET;
    end else if (s1_adv) begin
      unique case (s1_op)
        OP_CLEAR: begin
          pat_len   <= '0;
          ovf       <= 1'b0;
          init_row  <= ROW_RESET;
          match_row <= ROW_RESET;
        end
        OP_APPEND: begin
          if (has_room) begin
            pat_len   <= len_inc;
            init_row  <= init_row_next;
            match_row <= init_row_next;
          end else begin
            ovf       <= 1'b1;
            match_row <= init_row;
          end
        end
        OP_TEXT: begin
          match_row <= s1_last ? init_row : text_row;
        end
        OP_EMPTY: begin
          match_row <= init_row;
        end
        default: begin
          match_row <= init_row;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && gives_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_adv && gives_result) begin
      m_tdata <= {6'd0, ovf, hit};
    end
  end

endmodule

>>> sv/wpm_checker.sv
// Port-level checks for the wildcard pattern matcher, bound to the top level.
// No package dependency.
module wpm_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [1:0] s_tuser,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input stalls only behind a full, blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  // a fresh result comes from an input transfer, through the input register and the result register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching input transfer");

  // result padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:2] == 6'd0))
    else $error("nonzero padding in result");

endmodule

bind wildcard_pattern_matcher wpm_port_checker u_wpm_checker (.*);
